// ===== design/sfm_pkg.sv =====
// ----------------------------------------------------------------------------
// sfm_pkg
// Shared constants and types for the substring first-match search core:
// field widths, function codes and the control bundle sent to every cell.
// ----------------------------------------------------------------------------
package sfm_pkg;

    // default sizing of the core
    localparam int PATTERN_MAX_DEF = 64;
    localparam int OFFSET_BITS_DEF = 32;

    // fixed field widths
    localparam int DATA_W       = 8;
    localparam int INDEX_W      = 6;
    localparam int CFG_W        = 7;
    localparam int OUT_OFFSET_W = 32;

    // item function codes
    localparam logic FUNC_PATTERN = 1'b0;
    localparam logic FUNC_TEXT    = 1'b1;

    // control broadcast to the row of cells
    typedef struct packed {
        logic              shift;    // text byte enters, window moves one cell
        logic              rotate;   // pattern moves one cell around the ring
        logic [DATA_W-1:0] wr_byte;  // pattern byte for the cell being loaded
    } t_cell_ctrl;

endpackage

// ===== design/sfm_cell.sv =====
// ----------------------------------------------------------------------------
// sfm_cell
// One position of the search row: holds one text window byte and one
// pattern byte, passes both on to its neighbor and compares them.
// ----------------------------------------------------------------------------
module sfm_cell (
    input  logic                        i_clk,
    input  sfm_pkg::t_cell_ctrl         i_ctrl,
    input  logic                        i_load,
    input  logic                        i_active,
    input  logic [sfm_pkg::DATA_W-1:0]  i_win_prev,
    input  logic [sfm_pkg::DATA_W-1:0]  i_pat_prev,
    output logic [sfm_pkg::DATA_W-1:0]  o_win,
    output logic [sfm_pkg::DATA_W-1:0]  o_pat,
    output logic                        o_match
);
    import sfm_pkg::*;

    logic [DATA_W-1:0] r_win;
    logic [DATA_W-1:0] r_pat;

    // text window byte, shifted in from the newer neighbor
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_win <= i_win_prev;
        end
    end

    // pattern byte: direct load or one step of the ring rotation
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pat <= i_ctrl.wr_byte;
        end else if (i_ctrl.rotate) begin
            r_pat <= i_pat_prev;
        end
    end

    // positions past the pattern length always agree
    assign o_match = !i_active || (r_win == r_pat);
    assign o_win   = r_win;
    assign o_pat   = r_pat;

endmodule

// ===== design/substring_first_match_core.sv =====
// ----------------------------------------------------------------------------
// substring_first_match_core
// Streaming search for the first occurrence of a byte pattern in a text.
// ----------------------------------------------------------------------------
// The core takes one item per clock when not stalled, pattern loads and text
// bytes alike; a text's result goes through the compare stage to the output
// register after its last byte is taken. Each text byte moves the window one
// cell along a row of PATTERN_MAX cells; in the following cycle every cell
// compares its window byte with its pattern byte and the offset of the first
// hit is kept. Pattern bytes sit in the cells aligned to the current length,
// so a write to the length register starts a rotation of the pattern ring of
// one cell per cycle while the compare stage is empty, during which the input
// channel is stalled. The configuration port is always ready. The input also
// stalls while a finished result waits behind a stalled output register.
// ----------------------------------------------------------------------------
module substring_first_match_core #(
    parameter int PATTERN_MAX = sfm_pkg::PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = sfm_pkg::OFFSET_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sfm_pkg::CFG_W-1:0]        i_cfg_pattern_length,
    // input items
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_func,
    input  logic [sfm_pkg::DATA_W-1:0]       i_data_byte,
    input  logic [sfm_pkg::INDEX_W-1:0]      i_pattern_index,
    input  logic                             i_last,
    // result items
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_found,
    output logic [sfm_pkg::OUT_OFFSET_W-1:0] o_match_offset
);
    import sfm_pkg::*;

    localparam int IDX_W = $clog2(PATTERN_MAX);
    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int POS_W = IDX_W + 1;
    localparam int CMP_W = (OFFSET_BITS > LEN_W) ? OFFSET_BITS : LEN_W;

    // configuration and alignment state
    logic [LEN_W-1:0]       r_len;
    logic [LEN_W-1:0]       n_len;
    logic [IDX_W-1:0]       r_align;
    logic [IDX_W-1:0]       n_align;
    logic [IDX_W-1:0]       align_target;
    logic                   realign_busy;
    logic                   rotate;

    // text bookkeeping
    logic [OFFSET_BITS-1:0] r_count;
    logic [OFFSET_BITS-1:0] n_count;
    logic [OFFSET_BITS-1:0] count_inc;
    logic                   r_s1_valid;
    logic                   n_s1_valid;
    logic                   r_s1_last;
    logic [OFFSET_BITS-1:0] r_s1_count;
    logic                   r_match;
    logic [OFFSET_BITS-1:0] r_first;

    // output register
    logic                    r_out_valid;
    logic                    r_out_found;
    logic [OUT_OFFSET_W-1:0] r_out_offset;

    // handshake and datapath signals
    logic                   in_accept;
    logic                   text_accept;
    logic                   load_hit;
    logic                   index_ok;
    logic [IDX_W-1:0]       index_n;
    logic [POS_W-1:0]       pos_sum;
    logic [IDX_W-1:0]       load_pos;
    logic                   s1_block;
    logic                   s1_fire;
    logic                   all_match;
    logic                   hit;
    logic [OFFSET_BITS-1:0] hit_offset;
    t_cell_ctrl             cell_ctrl;

    logic [DATA_W-1:0]      w_win [PATTERN_MAX];
    logic [DATA_W-1:0]      w_pat [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] w_match;
    logic [PATTERN_MAX-1:0] w_load;
    logic [PATTERN_MAX-1:0] w_active;

    // ------------------------------------------------------------------
    // configuration: clamp the length, track the pattern ring alignment
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_len = r_len;
        if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_pattern_length == '0) begin
                n_len = LEN_W'(1);
            end else if (32'(i_cfg_pattern_length) > 32'(PATTERN_MAX)) begin
                n_len = LEN_W'(PATTERN_MAX);
            end else begin
                n_len = LEN_W'(i_cfg_pattern_length);
            end
        end
    end

    // the ring is aligned when cell k holds pattern byte (len-1-k) mod max
    assign align_target = (r_len == LEN_W'(PATTERN_MAX)) ? '0 : IDX_W'(r_len);
    assign realign_busy = (r_align != align_target);
    assign rotate       = realign_busy && !r_s1_valid;

    always_comb begin
        n_align = r_align;
        if (rotate) begin
            n_align = (r_align == IDX_W'(PATTERN_MAX - 1)) ? '0 : r_align + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= LEN_W'(1);
            r_align <= IDX_W'(1);
        end else begin
            r_len   <= n_len;
            r_align <= n_align;
        end
    end

    // ------------------------------------------------------------------
    // input handshake
    // ------------------------------------------------------------------
    assign s1_block    = r_s1_valid && r_s1_last && r_out_valid && i_out_stall;
    assign s1_fire     = r_s1_valid && !s1_block;
    assign o_in_stall  = realign_busy || s1_block;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign text_accept = in_accept && (i_func == FUNC_TEXT);

    // pattern load: cell position (align-1-index) mod max
    assign index_ok = (32'(i_pattern_index) < 32'(PATTERN_MAX));
    assign index_n  = IDX_W'(i_pattern_index);
    assign pos_sum  = POS_W'(r_align) + POS_W'(PATTERN_MAX - 1) - POS_W'(index_n);
    assign load_pos = (pos_sum >= POS_W'(PATTERN_MAX))
                    ? IDX_W'(pos_sum - POS_W'(PATTERN_MAX))
                    : IDX_W'(pos_sum);
    assign load_hit = in_accept && (i_func == FUNC_PATTERN) && index_ok;

    assign cell_ctrl.shift   = text_accept;
    assign cell_ctrl.rotate  = rotate;
    assign cell_ctrl.wr_byte = i_data_byte;

    // ------------------------------------------------------------------
    // row of cells
    // ------------------------------------------------------------------
    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
        assign w_load[k]   = load_hit && (load_pos == IDX_W'(k));
        assign w_active[k] = (LEN_W'(k) < r_len);

        if (k == 0) begin : g_head
            sfm_cell u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (cell_ctrl),
                .i_load     (w_load[k]),
                .i_active   (w_active[k]),
                .i_win_prev (i_data_byte),
                .i_pat_prev (w_pat[PATTERN_MAX-1]),
                .o_win      (w_win[k]),
                .o_pat      (w_pat[k]),
                .o_match    (w_match[k])
            );
        end else begin : g_body
            sfm_cell u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (cell_ctrl),
                .i_load     (w_load[k]),
                .i_active   (w_active[k]),
                .i_win_prev (w_win[k-1]),
                .i_pat_prev (w_pat[k-1]),
                .o_win      (w_win[k]),
                .o_pat      (w_pat[k]),
                .o_match    (w_match[k])
            );
        end
    end

    // ------------------------------------------------------------------
    // byte counter and compare stage
    // ------------------------------------------------------------------
    assign count_inc = (r_count == '1) ? r_count : r_count + 1'b1;

    always_comb begin
        n_count = r_count;
        if (text_accept) begin
            n_count = i_last ? '0 : count_inc;
        end
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (text_accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_fire) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (text_accept) begin
            r_s1_last  <= i_last;
            r_s1_count <= count_inc;
        end
    end

    // window agrees over the whole length once enough bytes are in
    assign all_match  = &w_match;
    assign hit        = all_match && (CMP_W'(r_s1_count) >= CMP_W'(r_len));
    assign hit_offset = OFFSET_BITS'(CMP_W'(r_s1_count) - CMP_W'(r_len));

    // first match record, cleared when a text ends
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
            r_first <= '0;
        end else if (s1_fire) begin
            if (r_s1_last) begin
                r_match <= 1'b0;
                r_first <= '0;
            end else if (!r_match && hit) begin
                r_match <= 1'b1;
                r_first <= hit_offset;
            end
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_last) begin
            r_out_found <= r_match || hit;
            if (r_match) begin
                r_out_offset <= OUT_OFFSET_W'(r_first);
            end else if (hit) begin
                r_out_offset <= OUT_OFFSET_W'(hit_offset);
            end else begin
                r_out_offset <= '0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_out_found;
    assign o_match_offset = r_out_offset;

endmodule
